// ===== sv/lpm_pkg.sv =====
// lpm_pkg: shared types and constants for the line pattern matcher
// no dependencies; imported by lpm_cell and line_pattern_matcher_top
package lpm_pkg;

  localparam int MAX_ELEMENTS = 32;
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int LEN_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int CFG_W        = 6;

  localparam logic [7:0] NEWLINE_CODE = 8'd10;

  // item kinds on the input tuser bit
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_CHAR = 1'b1;

  // repeat codes (unused code behaves as once)
  localparam logic [1:0] MODE_ONCE     = 2'd0;
  localparam logic [1:0] MODE_OPTIONAL = 2'd1;
  localparam logic [1:0] MODE_PLUS     = 2'd2;
  localparam logic [1:0] MODE_UNUSED   = 2'd3;

  // one stored pattern element
  typedef struct packed {
    logic [1:0] mode;
    logic       is_any;
    logic [7:0] ch;
  } elem_t;

  // per-cycle control broadcast to every cell
  typedef struct packed {
    logic       step;   // line byte other than newline
    logic       clear;  // newline: drop all positions
    logic [7:0] ch;     // current line byte
    elem_t      wr_elem; // element data on load
  } cell_ctl_t;

endpackage

// ===== sv/line_pattern_matcher_top.sv =====
// line_pattern_matcher_top: unanchored pattern matcher over a byte stream
// depends on lpm_pkg and lpm_cell
//
// Takes one word per cycle, back to back: a word is either a pattern element
// load (tuser 0) or a line byte (tuser 1). The nfa is a row of 32 cells, one
// per pattern element, each holding the position bit after its element; a
// line byte updates all positions in the same cycle through a ripple along
// the row for the optional-element skips. A newline byte yields one result
// word in the next cycle, 1 if the pattern matched anywhere in the line; an
// empty line gives 0. The input stalls only while a result word is held by
// out_tready low. Elements not loaded read as undefined. cfg_wdata sets the
// pattern length (values above 32 act as 32; 0 matches any non-empty line);
// write it only while idle.
module line_pattern_matcher_top
  import lpm_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  // configuration
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wdata,   // pattern_length
  // input words
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [15:0]      in_tdata,    // element_index[4:0], char_code[12:5],
                                        // is_any[13], repeat_mode[15:14]
  input  logic             in_tuser,    // op
  // result words
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata    // line_matches[0], zero fill above
);

  logic [CFG_W-1:0] len_r;
  logic [LEN_W-1:0] len_eff;
  logic             accept, is_nl;
  cell_ctl_t        ctl;
  logic [IDX_W-1:0] in_idx;

  logic [MAX_ELEMENTS:0]   b_chain, c_chain;
  logic [MAX_ELEMENTS:0]   hold_chain;
  logic [MAX_ELEMENTS-1:0] hits, wr_sel, range_v, at_len_v;

  logic match_r, match_nxt, has_r, has_nxt;
  logic out_valid_r, out_valid_nxt, out_bit_r, out_bit_nxt;

  // pattern length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (cfg_wr_en) begin
      len_r <= cfg_wdata;
    end
  end

  assign len_eff = (len_r > CFG_W'(MAX_ELEMENTS)) ? LEN_W'(MAX_ELEMENTS)
                                                  : LEN_W'(len_r);

  // handshake: output register frees in the same cycle it is taken
  assign in_tready = !out_valid_r || out_tready;
  assign accept    = in_tvalid && in_tready;
  assign in_idx    = in_tdata[IDX_W-1:0];
  assign is_nl     = (in_tdata[12:5] == NEWLINE_CODE);

  // control broadcast
  always_comb begin
    ctl.step           = accept && (in_tuser == OP_CHAR) && !is_nl;
    ctl.clear          = accept && (in_tuser == OP_CHAR) && is_nl;
    ctl.ch             = in_tdata[12:5];
    ctl.wr_elem.ch     = in_tdata[12:5];
    ctl.wr_elem.is_any = in_tdata[13];
    ctl.wr_elem.mode   = in_tdata[15:14];
  end

  // position zero is always live before a byte; its post-byte value is the
  // plus self-loop of the first element
  assign b_chain[0]                = 1'b1;
  assign c_chain[0]                = hold_chain[0];
  assign hold_chain[MAX_ELEMENTS]  = 1'b0;

  // row of cells
  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    assign wr_sel[k]   = accept && (in_tuser == OP_LOAD) && (in_idx == IDX_W'(k));
    assign range_v[k]  = (LEN_W'(k) < len_eff);
    assign at_len_v[k] = (LEN_W'(k + 1) == len_eff);

    lpm_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .wr_en     (wr_sel[k]),
      .in_range  (range_v[k]),
      .at_len    (at_len_v[k]),
      .b_in      (b_chain[k]),
      .c_in      (c_chain[k]),
      .hold_up   (hold_chain[k+1]),
      .b_out     (b_chain[k+1]),
      .c_out     (c_chain[k+1]),
      .hold      (hold_chain[k]),
      .match_hit (hits[k])
    );
  end

  // sticky match and line state
  always_comb begin
    match_nxt = match_r;
    has_nxt   = has_r;
    if (ctl.clear) begin
      match_nxt = 1'b0;
      has_nxt   = 1'b0;
    end else if (ctl.step) begin
      match_nxt = match_r || (|hits) || (len_eff == '0);
      has_nxt   = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      match_r <= 1'b0;
      has_r   <= 1'b0;
    end else begin
      match_r <= match_nxt;
      has_r   <= has_nxt;
    end
  end

  // result word register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_bit_nxt   = out_bit_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.clear) begin
      out_valid_nxt = 1'b1;
      out_bit_nxt   = match_r && has_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_bit_r <= out_bit_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'd0, out_bit_r};

endmodule

// ===== sv/lpm_cell.sv =====
// lpm_cell: one pattern element and the nfa position bit just after it
// depends on lpm_pkg; chained by line_pattern_matcher_top
module lpm_cell
  import lpm_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cell_ctl_t ctl,
  input  logic      wr_en,     // load this element
  input  logic      in_range,  // element index below pattern length
  input  logic      at_len,    // this cell's position equals pattern length
  input  logic      b_in,      // first closure at own element position
  input  logic      c_in,      // second closure at own element position
  input  logic      hold_up,   // plus self-loop from next cell
  output logic      b_out,
  output logic      c_out,
  output logic      hold,
  output logic      match_hit
);

  elem_t elem_r;
  logic  act_r, act_nxt;
  logic  acc, opt, plus, fwd, nxt_pos;

  // element storage, no reset
  always_ff @(posedge clk) begin
    if (wr_en) begin
      elem_r <= ctl.wr_elem;
    end
  end

  // element decode
  assign acc  = elem_r.is_any | (elem_r.ch == ctl.ch);
  assign opt  = (elem_r.mode == MODE_OPTIONAL);
  assign plus = (elem_r.mode == MODE_PLUS);

  // closure before the byte: stored position plus optional skip
  assign b_out = in_range & (act_r | (b_in & opt));

  // byte transition and plus self-loop
  assign fwd     = b_in & acc & in_range;
  assign hold    = fwd & plus;
  assign nxt_pos = fwd | hold_up;

  // closure after the byte
  assign c_out = in_range & (nxt_pos | (c_in & opt));

  assign match_hit = at_len & (b_out | c_out);

  // position bit update
  always_comb begin
    act_nxt = act_r;
    if (ctl.clear) begin
      act_nxt = 1'b0;
    end else if (ctl.step) begin
      act_nxt = c_out;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
    end else begin
      act_r <= act_nxt;
    end
  end

endmodule
